// ===== hdl/llp_pkg.sv =====
// Shared types and constants of the LL(1) table-driven parser.
// No dependencies; every other file of the block takes names from here.
package llp_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TOKEN = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_CONSUMED = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_LIMIT    = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_SYMBOL = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_EPSILON      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [6:0] START_SYMBOL_RST = 7'd83;
  localparam logic [7:0] END_MARKER_RST   = 8'd36;
  localparam logic [7:0] EPSILON_RST      = 8'd101;

  // Code of the first nonterminal letter.
  localparam logic [7:0] NT_BASE = 8'd65;

  // Table address is {row, lookahead}.
  localparam int TA_W = 13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  row;
    logic [7:0]  lookahead;
    logic        valid;
    logic [3:0]  len;
    logic [63:0] rhs;
    logic [7:0]  tok;
  } llp_item_t;

  typedef struct packed {
    logic        present;
    logic [3:0]  len;
    logic [63:0] rhs;
  } llp_cell_t;

endpackage

// ===== hdl/llp_queue.sv =====
// Two-entry word queue between the front and back parts of the parser.
// Depends on llp_pkg for the queued word type.
module llp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  llp_pkg::llp_item_t push_word,
  input  logic              pop,
  output llp_pkg::llp_item_t head,
  output logic              empty,
  output logic              full
);

  llp_pkg::llp_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/llp_front.sv =====
// Front part of the parser: takes command words, drops those that do nothing
// and saturates right-hand side lengths. Depends on llp_pkg.
module llp_front #(
  parameter int MAX_RHS          = 8,
  parameter int NONTERMINAL_ROWS = 26
) (
  input  logic              start,
  input  logic              stall,
  input  llp_pkg::llp_item_t in_word,
  output logic              push,
  output llp_pkg::llp_item_t push_word
);

  logic taken;
  logic useful;

  assign taken = start && !stall;

  always_comb begin
    push_word = in_word;
    if (in_word.len > 4'(MAX_RHS)) begin
      push_word.len = 4'(MAX_RHS);
    end
    case (in_word.kind)
      llp_pkg::KIND_WRITE: useful = (in_word.row < 5'(NONTERMINAL_ROWS));
      llp_pkg::KIND_START: useful = 1'b1;
      llp_pkg::KIND_TOKEN: useful = 1'b1;
      default:             useful = 1'b0;
    endcase
  end

  assign push = taken && useful;

endmodule

// ===== hdl/llp_back.sv =====
// Back part of the parser: parse table memory, symbol stack memory and the
// expansion sequencer. Depends on llp_pkg.
module llp_back #(
  parameter int STACK_DEPTH      = 64,
  parameter int NONTERMINAL_ROWS = 26,
  parameter int MAX_EXPAND       = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        start_symbol,
  input  logic [7:0]        end_marker,
  input  logic [7:0]        epsilon_symbol,
  input  llp_pkg::llp_item_t head,
  input  logic              empty,
  output logic              pop,
  output logic              clearing,
  output logic              result_valid,
  output logic [2:0]        status,
  output logic [6:0]        expansions,
  output logic [6:0]        stack_level
);

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int EXP_W  = $clog2(MAX_EXPAND + 1);
  localparam int TDEPTH = NONTERMINAL_ROWS * 256;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_START2 = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_TOP    = 3'd4;
  localparam logic [2:0] S_CELL   = 3'd5;
  localparam logic [2:0] S_PUSH   = 3'd6;

  llp_pkg::llp_cell_t tmem [TDEPTH];
  logic [7:0]         smem [STACK_DEPTH];

  logic [2:0]            state;
  logic [llp_pkg::TA_W-1:0] clr_addr;
  logic [SP_W-1:0]       sp;
  logic                  active;
  logic [EXP_W-1:0]      exps;
  logic [7:0]            tok;
  logic [3:0]            idx;
  logic [63:0]           rhs_q;
  llp_pkg::llp_cell_t    cell_q;
  logic [7:0]            top_q;

  logic                     twe;
  logic [llp_pkg::TA_W-1:0] twaddr;
  llp_pkg::llp_cell_t       twdata;
  logic [llp_pkg::TA_W-1:0] traddr;
  logic                     swe;
  logic [IDX_W-1:0]         swaddr;
  logic [7:0]               swdata;
  logic [SP_W-1:0]          sp_m1;
  logic [7:0]               row_off;
  logic [3:0]               n_push;
  logic [SP_W:0]            new_level;
  logic [2:0]               sel;
  logic [7:0]               push_sym;

  assign sp_m1    = sp - 1'b1;
  assign row_off  = top_q - llp_pkg::NT_BASE;
  assign traddr   = {row_off[4:0], tok};
  assign pop      = (state == S_IDLE) && !empty;
  assign clearing = (state == S_CLEAR);
  assign sel      = 3'(idx - 4'd1);
  assign push_sym = rhs_q[{sel, 3'b000} +: 8];

  // Symbols the production would push, epsilon not counted.
  always_comb begin
    n_push = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < cell_q.len) && (cell_q.rhs[8*i +: 8] != epsilon_symbol)) begin
        n_push = n_push + 4'd1;
      end
    end
    new_level = {1'b0, sp_m1} + (SP_W + 1)'(n_push);
  end

  always_comb begin
    twe    = 1'b0;
    twaddr = clr_addr;
    twdata = '0;
    swe    = 1'b0;
    swaddr = sp[IDX_W-1:0];
    swdata = push_sym;
    case (state)
      S_CLEAR: twe = 1'b1;
      S_IDLE: begin
        if (!empty && head.kind == llp_pkg::KIND_WRITE) begin
          twe    = 1'b1;
          twaddr = {head.row, head.lookahead};
          twdata = '{present: head.valid, len: head.len, rhs: head.rhs};
        end
        if (!empty && head.kind == llp_pkg::KIND_START) begin
          swe    = 1'b1;
          swaddr = '0;
          swdata = end_marker;
        end
      end
      S_START2: begin
        swe    = 1'b1;
        swaddr = IDX_W'(1);
        swdata = {1'b0, start_symbol};
      end
      S_PUSH: swe = (idx != 4'd0) && (push_sym != epsilon_symbol);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (twe) begin
      tmem[twaddr] <= twdata;
    end
    cell_q <= tmem[traddr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[swaddr] <= swdata;
    end
    top_q <= smem[sp_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      sp           <= '0;
      active       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == llp_pkg::TA_W'(TDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            case (head.kind)
              llp_pkg::KIND_START: state <= S_START2;
              llp_pkg::KIND_TOKEN: begin
                tok  <= head.tok;
                exps <= '0;
                if (active) begin
                  state <= S_READ;
                end else begin
                  result_valid <= 1'b1;
                  status       <= llp_pkg::ST_IDLE;
                  expansions   <= 7'd0;
                  stack_level  <= 7'(sp);
                end
              end
              default: ;
            endcase
          end
        end
        S_START2: begin
          sp     <= SP_W'(2);
          active <= 1'b1;
          state  <= S_IDLE;
        end
        S_READ: begin
          if (sp == '0) begin
            result_valid <= 1'b1;
            status       <= llp_pkg::ST_REJECTED;
            expansions   <= 7'(exps);
            stack_level  <= 7'(sp);
            active       <= 1'b0;
            state        <= S_IDLE;
          end else begin
            state <= S_TOP;
          end
        end
        S_TOP: begin
          state       <= S_IDLE;
          expansions  <= 7'(exps);
          stack_level <= 7'(sp);
          if (top_q == end_marker) begin
            result_valid <= 1'b1;
            status       <= (tok == end_marker) ? llp_pkg::ST_ACCEPTED : llp_pkg::ST_REJECTED;
            active       <= 1'b0;
          end else if (top_q == tok) begin
            result_valid <= 1'b1;
            status       <= llp_pkg::ST_CONSUMED;
            sp           <= sp_m1;
            stack_level  <= 7'(sp_m1);
          end else if (top_q < llp_pkg::NT_BASE || row_off >= 8'(NONTERMINAL_ROWS)) begin
            result_valid <= 1'b1;
            status       <= llp_pkg::ST_REJECTED;
            active       <= 1'b0;
          end else begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          expansions  <= 7'(exps);
          stack_level <= 7'(sp);
          if (!cell_q.present) begin
            result_valid <= 1'b1;
            status       <= llp_pkg::ST_REJECTED;
            active       <= 1'b0;
            state        <= S_IDLE;
          end else if (exps >= EXP_W'(MAX_EXPAND)) begin
            result_valid <= 1'b1;
            status       <= llp_pkg::ST_LIMIT;
            active       <= 1'b0;
            state        <= S_IDLE;
          end else if (new_level > (SP_W + 1)'(STACK_DEPTH)) begin
            result_valid <= 1'b1;
            status       <= llp_pkg::ST_OVERFLOW;
            active       <= 1'b0;
            state        <= S_IDLE;
          end else begin
            sp    <= sp_m1;
            idx   <= cell_q.len;
            rhs_q <= cell_q.rhs;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (idx == 4'd0) begin
            exps  <= exps + 1'b1;
            state <= S_READ;
          end else begin
            idx <= idx - 4'd1;
            if (push_sym != epsilon_symbol) begin
              sp <= sp + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !result_valid) else $error("result during table clear");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_idle_no_exps: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == llp_pkg::ST_IDLE |-> expansions == 7'd0)
    else $error("expansions reported for inactive parse");
  a_end_clears_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != llp_pkg::ST_CONSUMED && status != llp_pkg::ST_IDLE |-> !active)
    else $error("parse still active after final status");
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    swe && state == S_PUSH |-> sp < SP_W'(STACK_DEPTH)) else $error("push past stack");
`endif

endmodule

// ===== hdl/ll1_table_driven_parser_unit.sv =====
// Top level of the LL(1) table-driven parser.
// Depends on llp_pkg, llp_front, llp_queue and llp_back.
//
// A table-driven LL(1) predictive parser. Command words arrive on start/busy:
// kind 0 writes one parse-table cell, kind 1 begins a new parse, kind 2 hands
// over one token; only token words give a result, and kind 3 or a write to a
// row beyond the table is dropped. The front part takes a word whenever busy
// is low and places it in a two-word queue, so a new word can be taken while
// the back part still works on an earlier one; busy rises when the queue is
// full. The back part handles one word at a time: a table write, or a token
// for an idle parser, is handled in the idle state; a start word also passes
// through a second state that pushes the start symbol; a token goes through
// a stack inspection, a table lookup when a nonterminal is on top, and the
// push of the right-hand side symbols one by one for each expansion, after
// which the stack is inspected anew; the table read is registered. Each
// result is shown for exactly one cycle with result_valid high and cannot
// be held off. After reset the table memory is cleared one cell a cycle,
// all NONTERMINAL_ROWS times 256 cells of it, during which busy is high;
// configuration writes are taken at all times, cfg_ready being always high.
module ll1_table_driven_parser_unit #(
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_RHS          = 8,
  parameter int NONTERMINAL_ROWS = 26,
  parameter int MAX_EXPAND       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [4:0]  cell_row,
  input  logic [7:0]  cell_lookahead,
  input  logic        cell_valid,
  input  logic [3:0]  rhs_length,
  input  logic [63:0] rhs_symbols,
  input  logic [7:0]  token,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [6:0]  expansions,
  output logic [6:0]  stack_level
);

  logic [6:0] start_symbol;
  logic [7:0] end_marker;
  logic [7:0] epsilon_symbol;

  llp_pkg::llp_item_t in_word;
  llp_pkg::llp_item_t push_word;
  llp_pkg::llp_item_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic clearing;

  assign cfg_ready = 1'b1;
  assign busy      = full || clearing;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_symbol   <= llp_pkg::START_SYMBOL_RST;
      end_marker     <= llp_pkg::END_MARKER_RST;
      epsilon_symbol <= llp_pkg::EPSILON_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        llp_pkg::REG_START_SYMBOL: start_symbol   <= cfg_data[6:0];
        llp_pkg::REG_END_MARKER:   end_marker     <= cfg_data;
        llp_pkg::REG_EPSILON:      epsilon_symbol <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_word = '{kind: kind, row: cell_row, lookahead: cell_lookahead,
                     valid: cell_valid, len: rhs_length, rhs: rhs_symbols,
                     tok: token};

  llp_front #(
    .MAX_RHS          (MAX_RHS),
    .NONTERMINAL_ROWS (NONTERMINAL_ROWS)
  ) u_front (
    .start     (start),
    .stall     (busy),
    .in_word   (in_word),
    .push      (push),
    .push_word (push_word)
  );

  llp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  llp_back #(
    .STACK_DEPTH      (STACK_DEPTH),
    .NONTERMINAL_ROWS (NONTERMINAL_ROWS),
    .MAX_EXPAND       (MAX_EXPAND)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .start_symbol   (start_symbol),
    .end_marker     (end_marker),
    .epsilon_symbol (epsilon_symbol),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .clearing       (clearing),
    .result_valid   (result_valid),
    .status         (status),
    .expansions     (expansions),
    .stack_level    (stack_level)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the LL(1) table-driven parser unit.
// Depends on llp_pkg and ll1_table_driven_parser_unit; stands alone otherwise.
`timescale 1ns / 100ps

module testbench;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_RHS     = 8;
  localparam int NT_ROWS     = 26;
  localparam int MAX_EXPAND  = 64;
  localparam int CELLS       = NT_ROWS * 256;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 30;

  typedef struct {
    logic [2:0] st;
    logic [6:0] ex;
    logic [6:0] lvl;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = llp_pkg::KIND_WRITE;
  logic [4:0]  cell_row = '0;
  logic [7:0]  cell_lookahead = '0;
  logic        cell_valid = 1'b0;
  logic [3:0]  rhs_length = '0;
  logic [63:0] rhs_symbols = '0;
  logic [7:0]  token = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = llp_pkg::REG_START_SYMBOL;
  logic [7:0]  cfg_data = '0;
  logic        result_valid;
  logic [2:0]  status;
  logic [6:0]  expansions;
  logic [6:0]  stack_level;

  ll1_table_driven_parser_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be driven, and the results the parser model predicts.
  llp_pkg::llp_item_t word_q[$];
  parse_result_t      result_q[$];
  int                 mismatches = 0;
  int                 gap = 0;
  bit                 no_gaps = 1'b0;

  // Parser model: table, symbol stack and configuration.
  logic [63:0] tbl_rhs[CELLS];
  logic [3:0]  tbl_len[CELLS];
  bit          tbl_present[CELLS];
  logic [7:0]  sym_stack[STACK_DEPTH];
  int          sp = 0;
  bit          parsing = 1'b0;
  logic [6:0]  m_start = llp_pkg::START_SYMBOL_RST;
  logic [7:0]  m_end = llp_pkg::END_MARKER_RST;
  logic [7:0]  m_eps = llp_pkg::EPSILON_RST;

  // Shadow of the table used by the sentence generator, updated as words are queued.
  logic [63:0] gen_rhs[CELLS];
  int          gen_len[CELLS];
  bit          gen_present[CELLS];
  logic [7:0]  gen_start = llp_pkg::START_SYMBOL_RST;
  logic [7:0]  gen_end = llp_pkg::END_MARKER_RST;
  logic [7:0]  gen_eps = llp_pkg::EPSILON_RST;
  logic [7:0]  terms[$];
  logic [7:0]  nts[$];

  function automatic void parse_token(input logic [7:0] tk, output logic [2:0] st,
                                      output int ex);
    logic [7:0] top;
    logic [7:0] s;
    int slot, n;
    bit done;
    ex = 0;
    done = 1'b0;
    while (!done) begin
      done = 1'b1;
      if (sp == 0) begin
        st = llp_pkg::ST_REJECTED;
      end else begin
        top = sym_stack[sp-1];
        if (top == m_end) begin
          st = (tk == m_end) ? llp_pkg::ST_ACCEPTED : llp_pkg::ST_REJECTED;
        end else if (top == tk) begin
          sp--;
          st = llp_pkg::ST_CONSUMED;
        end else if (top < llp_pkg::NT_BASE || top - llp_pkg::NT_BASE >= NT_ROWS) begin
          st = llp_pkg::ST_REJECTED;
        end else begin
          slot = (top - llp_pkg::NT_BASE) * 256 + tk;
          if (!tbl_present[slot]) begin
            st = llp_pkg::ST_REJECTED;
          end else if (ex >= MAX_EXPAND) begin
            st = llp_pkg::ST_LIMIT;
          end else begin
            n = 0;
            for (int i = 0; i < tbl_len[slot]; i++)
              if (tbl_rhs[slot][8*i +: 8] != m_eps) n++;
            if (sp - 1 + n > STACK_DEPTH) begin
              st = llp_pkg::ST_OVERFLOW;
            end else begin
              // Replace the nonterminal by its production, last symbol deepest.
              sp--;
              for (int i = tbl_len[slot] - 1; i >= 0; i--) begin
                s = tbl_rhs[slot][8*i +: 8];
                if (s != m_eps) begin
                  sym_stack[sp] = s;
                  sp++;
                end
              end
              ex++;
              done = 1'b0;
            end
          end
        end
      end
    end
  endfunction

  function automatic void model_word(input llp_pkg::llp_item_t w);
    parse_result_t r;
    int slot, ex;
    case (w.kind)
      llp_pkg::KIND_WRITE: begin
        if (w.row < NT_ROWS) begin
          slot = w.row * 256 + w.lookahead;
          tbl_present[slot] = w.valid;
          tbl_len[slot] = (w.len > MAX_RHS) ? 4'(MAX_RHS) : w.len;
          tbl_rhs[slot] = w.rhs;
        end
      end
      llp_pkg::KIND_START: begin
        sym_stack[0] = m_end;
        sym_stack[1] = {1'b0, m_start};
        sp = 2;
        parsing = 1'b1;
      end
      llp_pkg::KIND_TOKEN: begin
        if (!parsing) begin
          r.st = llp_pkg::ST_IDLE;
          r.ex = '0;
        end else begin
          parse_token(w.tok, r.st, ex);
          if (r.st != llp_pkg::ST_CONSUMED) parsing = 1'b0;
          r.ex = 7'(ex);
        end
        r.lvl = 7'(sp);
        result_q.insert(result_q.size(), r);
      end
      default: ;
    endcase
  endfunction

  function automatic int next_gap();
    int p;
    p = $urandom_range(99);
    if (no_gaps || p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: a word stays on the ports until it is taken at an edge where busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy)
        model_word('{kind, cell_row, cell_lookahead, cell_valid, rhs_length,
                     rhs_symbols, token});
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          llp_pkg::REG_START_SYMBOL: m_start = cfg_data[6:0];
          llp_pkg::REG_END_MARKER:   m_end = cfg_data;
          llp_pkg::REG_EPSILON:      m_eps = cfg_data;
          default: ;
        endcase
      end
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (word_q.size() > 0) begin
          llp_pkg::llp_item_t w;
          w = word_q.pop_front();
          kind <= w.kind;
          cell_row <= w.row;
          cell_lookahead <= w.lookahead;
          cell_valid <= w.valid;
          rhs_length <= w.len;
          rhs_symbols <= w.rhs;
          token <= w.tok;
          start <= 1'b1;
          gap <= next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d expansions %0d level %0d",
                   status, expansions, stack_level);
      end else begin
        parse_result_t r;
        r = result_q.pop_front();
        if (status !== r.st || expansions !== r.ex || stack_level !== r.lvl) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     r.st, r.ex, r.lvl, status, expansions, stack_level);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word, result or register write moves.
  int stalled = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  // Queues one word and keeps the generator's view of the table in step.
  function automatic void push_word(input logic [1:0] k, input logic [4:0] row,
                                    input logic [7:0] la, input logic v,
                                    input logic [3:0] len, input logic [63:0] rhs,
                                    input logic [7:0] tk);
    int slot;
    word_q.insert(word_q.size(), '{k, row, la, v, len, rhs, tk});
    if (k == llp_pkg::KIND_WRITE && row < NT_ROWS) begin
      slot = row * 256 + la;
      gen_present[slot] = v;
      gen_len[slot] = (len > MAX_RHS) ? MAX_RHS : len;
      gen_rhs[slot] = rhs;
    end
  endfunction

  function automatic logic [63:0] pack_syms(input string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic void put_cell(input byte nt, input byte la, input string s);
    push_word(llp_pkg::KIND_WRITE, 5'(nt - llp_pkg::NT_BASE), la, 1'b1, 4'(s.len()),
              pack_syms(s), '0);
  endfunction

  function automatic void put_token(input logic [7:0] tk);
    push_word(llp_pkg::KIND_TOKEN, '0, '0, 1'b0, '0, '0, tk);
  endfunction

  function automatic void put_start();
    push_word(llp_pkg::KIND_START, '0, '0, 1'b0, '0, '0, '0);
  endfunction

  function automatic bit is_nt(input logic [7:0] s);
    return s >= llp_pkg::NT_BASE && s - llp_pkg::NT_BASE < NT_ROWS && s != gen_end;
  endfunction

  function automatic logic [7:0] pick_term();
    return terms[$urandom_range(terms.size() - 1)];
  endfunction

  // A production keyed on column la: la as first non-epsilon symbol, then terminals
  // and, unless terminal_only, nonterminals, with epsilon bytes sprinkled in that the parser must skip.
  function automatic void put_production(input logic [7:0] row, input logic [7:0] la,
                                         input bit terminal_only);
    logic [63:0] rhs;
    int n, extra;
    rhs = {$urandom, $urandom};
    n = 0;
    if ($urandom_range(3) == 0) begin
      rhs[8*n +: 8] = gen_eps;
      n++;
    end
    rhs[8*n +: 8] = la;
    n++;
    extra = $urandom_range(4);
    for (int i = 0; i < extra && n < 8; i++) begin
      if ($urandom_range(4) == 0)
        rhs[8*n +: 8] = gen_eps;
      else if (!terminal_only && $urandom_range(2) == 0)
        rhs[8*n +: 8] = nts[$urandom_range(nts.size() - 1)];
      else
        rhs[8*n +: 8] = pick_term();
      n++;
    end
    push_word(llp_pkg::KIND_WRITE, 5'(row - llp_pkg::NT_BASE), la, 1'b1,
              (n == 8 && $urandom_range(1)) ? 4'($urandom_range(15, 9)) : 4'(n),
              rhs, '0);
  endfunction

  function automatic void build_grammar();
    logic [7:0] s;
    terms.delete();
    nts.delete();
    while (terms.size() < 6) begin
      s = 8'($urandom_range(255));
      if (!(s >= llp_pkg::NT_BASE && s < llp_pkg::NT_BASE + NT_ROWS) && s != gen_eps &&
          s != gen_end && !(s inside {terms}))
        terms.insert(terms.size(), s);
    end
    nts.insert(nts.size(), gen_start);
    while (nts.size() < 4) begin
      s = 8'($urandom_range(llp_pkg::NT_BASE + NT_ROWS - 1, llp_pkg::NT_BASE));
      if (!(s inside {nts}) && s != gen_end) nts.insert(nts.size(), s);
    end
    foreach (nts[i]) begin
      put_production(nts[i], terms[i % 6], 1'b1);
      put_production(nts[i], terms[(i + 1) % 6], 1'b0);
      if ($urandom_range(1)) put_production(nts[i], terms[(i + 3) % 6], 1'b0);
    end
  endfunction

  // One sentence derived leftmost from the shadow table, ending with the end marker
  // or now and then a random token; a sentence that cannot be continued ends in a random token.
  function automatic int put_sentence(input int max_tokens);
    logic [7:0] dstk[$];
    logic [7:0] top, s;
    int cands[$];
    int flat[$];
    int slot, ntok, c;
    bit has_nt, broken;
    put_start();
    dstk.insert(dstk.size(), gen_start);
    ntok = 0;
    broken = 1'b0;
    while (dstk.size() > 0 && ntok < max_tokens && !broken) begin
      top = dstk.pop_back();
      if (!is_nt(top)) begin
        put_token(top);
        ntok++;
      end else begin
        cands.delete();
        flat.delete();
        for (int col = 0; col < 256; col++) begin
          slot = (top - llp_pkg::NT_BASE) * 256 + col;
          if (gen_present[slot]) begin
            c = -1;
            has_nt = 1'b0;
            for (int i = 0; i < gen_len[slot]; i++) begin
              s = gen_rhs[slot][8*i +: 8];
              if (s != gen_eps) begin
                if (c < 0) c = s;
                if (is_nt(s)) has_nt = 1'b1;
              end
            end
            if (c == col && !is_nt(8'(c))) begin
              cands.insert(cands.size(), slot);
              if (!has_nt) flat.insert(flat.size(), slot);
            end
          end
        end
        if ((dstk.size() > 10 || ntok > max_tokens / 2) && flat.size() > 0)
          cands = flat;
        if (cands.size() == 0) begin
          broken = 1'b1;
        end else begin
          slot = cands[$urandom_range(cands.size() - 1)];
          for (int i = gen_len[slot] - 1; i >= 0; i--) begin
            s = gen_rhs[slot][8*i +: 8];
            if (s != gen_eps) dstk.insert(dstk.size(), s);
          end
        end
      end
    end
    put_token((broken || $urandom_range(9) == 0) ? 8'($urandom_range(255)) : gen_end);
    return ntok + 2;
  endfunction

  function automatic void put_noise();
    logic [1:0] k;
    k = 2'($urandom_range(3));
    // Writes are kept rare so the grammar mostly survives.
    if (k == llp_pkg::KIND_WRITE && $urandom_range(3) != 0) k = llp_pkg::KIND_TOKEN;
    push_word(k, 5'($urandom_range(31)), 8'($urandom_range(255)), 1'($urandom_range(1)),
              4'($urandom_range(15)), {$urandom, $urandom}, 8'($urandom_range(255)));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until the parser has taken every word and delivered every result,
  // then lets trailing start and write words drain from its queue.
  task automatic drain();
    while (word_q.size() != 0 || start || result_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] p);
    write_reg(llp_pkg::REG_START_SYMBOL, s);
    write_reg(llp_pkg::REG_END_MARKER, e);
    write_reg(llp_pkg::REG_EPSILON, p);
    gen_start = {1'b0, s[6:0]};
    gen_end = e;
    gen_eps = p;
  endtask

  initial begin
    int budget;
    logic [7:0] e, p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset configuration: start 'S', end '$', epsilon 'e'.
    put_token("a");                            // token with no parse running
    put_cell("S", "a", "aAb");
    put_cell("A", "c", "ce");                  // epsilon inside a production
    put_cell("A", "d", "d");
    put_cell("S", "x", "L");
    put_cell("L", "x", "L");                   // endless chain, hits the limit
    put_cell("S", "y", "SSSSSSSS");            // grows until the stack overflows
    push_word(llp_pkg::KIND_WRITE, 5'd18, "z", 1'b1, 4'd15, pack_syms("zzzzzzzz"), '0);
    push_word(llp_pkg::KIND_WRITE, 5'd31, "a", 1'b1, 4'd1, '1, '0);  // row beyond the table
    push_word(2'd3, '0, '0, 1'b0, '0, '0, '0);                        // unused kind
    put_start(); put_token("a"); put_token("c"); put_token("b"); put_token("$");
    put_start(); put_token("x");
    put_start(); put_token("y");
    put_start(); put_token("z"); put_token("$");
    put_start(); put_token("a"); put_token("b"); put_token("b");
    push_word(llp_pkg::KIND_WRITE, 5'd18, "y", 1'b0, '0, '0, '0);    // clear the cell again
    put_start(); put_token("y");
    drain();

    // Random phases, each under its own configuration and grammar.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: set_config(8'd65, 8'd0, 8'd255);
        2: set_config(8'd90, 8'd255, 8'd0);
        3: set_config(8'd83, 8'd36, 8'd101);
        default: begin
          do e = 8'($urandom_range(255));
          while (e >= llp_pkg::NT_BASE && e < llp_pkg::NT_BASE + NT_ROWS);
          do p = 8'($urandom_range(255));
          while ((p >= llp_pkg::NT_BASE && p < llp_pkg::NT_BASE + NT_ROWS) || p == e);
          set_config(8'($urandom_range(llp_pkg::NT_BASE + NT_ROWS - 1, llp_pkg::NT_BASE)),
                     e, p);
        end
      endcase
      no_gaps = (ph == 2);
      build_grammar();
      budget = 300;
      while (budget > 0) begin
        if ($urandom_range(3) != 0) begin
          budget -= put_sentence($urandom_range(20, 3));
        end else begin
          put_noise();
          budget--;
        end
      end
      drain();
    end

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
